// File: rtl/bmtod_pkg.sv
`default_nettype none

package bmtod_pkg;

  // Field and state widths
  localparam int MODE_W      = 2;
  localparam int OFFSET_W    = 2;
  localparam int DATA_W      = 8;
  localparam int CYCLES_W    = 13;
  localparam int PRESCALER_W = 14;
  localparam int HUNDREDTH_W = 7;

  // Default timing constants
  localparam int DEFAULT_CYCLES_PER_HUNDREDTH  = 10000;
  localparam int DEFAULT_HUNDREDTHS_PER_SECOND = 100;

  // Carry limits for the time registers
  localparam logic [DATA_W-1:0] SECONDS_LIMIT = 8'd60;
  localparam logic [DATA_W-1:0] MINUTES_LIMIT = 8'd60;
  localparam logic [DATA_W-1:0] HOURS_LIMIT   = 8'd24;

  // Transaction kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  // Register offsets
  typedef enum logic [OFFSET_W-1:0] {
    OFS_HOURS   = 2'd0,
    OFS_MINUTES = 2'd1,
    OFS_SECONDS = 2'd2
  } offset_t;

endpackage

`default_nettype wire

// File: rtl/bus_mapped_time_of_day_clock.sv
// The read_data result of an accepted transaction is registered and shown in the cycle after acceptance.
// Throughput: one transaction per cycle; in_ready drops only while a result
// waits in the output register and out_ready is low.
// Each transaction is decoded and the time state updated in the accept cycle.
// Reset (rst, synchronous, active high) loads the prescaler and hundredths
// counter with their full counts, clears hours/minutes/seconds and the output.
`default_nettype none

module bus_mapped_time_of_day_clock #(
  parameter int CYCLES_PER_HUNDREDTH  = bmtod_pkg::DEFAULT_CYCLES_PER_HUNDREDTH,
  parameter int HUNDREDTHS_PER_SECOND = bmtod_pkg::DEFAULT_HUNDREDTHS_PER_SECOND
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bmtod_pkg::MODE_W-1:0]     mode,
  input  wire logic [bmtod_pkg::OFFSET_W-1:0]   offset,
  input  wire logic [bmtod_pkg::DATA_W-1:0]     write_data,
  input  wire logic [bmtod_pkg::CYCLES_W-1:0]   elapsed_cycles,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [bmtod_pkg::DATA_W-1:0]          read_data
);
  import bmtod_pkg::*;

  localparam logic [PRESCALER_W-1:0] PRESC_RELOAD = PRESCALER_W'(CYCLES_PER_HUNDREDTH);
  localparam logic [HUNDREDTH_W-1:0] HUND_RELOAD  = HUNDREDTH_W'(HUNDREDTHS_PER_SECOND);

  // Time state
  logic [PRESCALER_W-1:0] cycle_prescaler, cycle_prescaler_next;
  logic [HUNDREDTH_W-1:0] hundredths_counter, hundredths_counter_next;
  logic [DATA_W-1:0]      seconds_reg, seconds_reg_next;
  logic [DATA_W-1:0]      minutes_reg, minutes_reg_next;
  logic [DATA_W-1:0]      hours_reg, hours_reg_next;
  logic [DATA_W-1:0]      read_data_next;

  logic accept;

  // Tick arithmetic
  logic signed [PRESCALER_W+1:0] presc_diff;
  logic signed [PRESCALER_W+1:0] presc_reload_sum;
  logic                          underflow;
  logic [HUNDREDTH_W-1:0]        hund_dec;

  // Carry chain for one second
  logic [DATA_W-1:0] sec_inc, min_inc, hour_inc;
  logic [DATA_W-1:0] sec_adv, min_adv, hour_adv;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  // Prescaler subtraction and single reload
  always_comb begin
    presc_diff = $signed({2'b00, cycle_prescaler})
               - $signed({3'b000, elapsed_cycles});
    presc_reload_sum = presc_diff + $signed({2'b00, PRESC_RELOAD});
    underflow = (presc_diff <= 0);
    hund_dec = (hundredths_counter != '0) ? hundredths_counter - 1'b1 : hundredths_counter;
  end

  // Seconds advance with carries into minutes and hours
  always_comb begin
    sec_inc  = seconds_reg + 1'b1;
    min_inc  = minutes_reg + 1'b1;
    hour_inc = hours_reg + 1'b1;
    sec_adv  = sec_inc;
    min_adv  = minutes_reg;
    hour_adv = hours_reg;
    if (sec_inc >= SECONDS_LIMIT) begin
      sec_adv = '0;
      min_adv = min_inc;
      if (min_inc >= MINUTES_LIMIT) begin
        min_adv  = '0;
        hour_adv = (hour_inc >= HOURS_LIMIT) ? '0 : hour_inc;
      end
    end
  end

  // Transaction decode
  always_comb begin
    cycle_prescaler_next    = cycle_prescaler;
    hundredths_counter_next = hundredths_counter;
    seconds_reg_next        = seconds_reg;
    minutes_reg_next        = minutes_reg;
    hours_reg_next          = hours_reg;
    read_data_next          = '0;
    case (mode)
      MODE_TICK: begin
        if (elapsed_cycles != '0) begin
          if (underflow) begin
            cycle_prescaler_next = presc_reload_sum[PRESCALER_W+1] ? '0
                                 : presc_reload_sum[PRESCALER_W-1:0];
            if (hund_dec == '0) begin
              hundredths_counter_next = HUND_RELOAD;
              seconds_reg_next        = sec_adv;
              minutes_reg_next        = min_adv;
              hours_reg_next          = hour_adv;
            end else begin
              hundredths_counter_next = hund_dec;
            end
          end else begin
            cycle_prescaler_next = presc_diff[PRESCALER_W-1:0];
          end
        end
      end
      MODE_READ: begin
        case (offset)
          OFS_HOURS:   read_data_next = hours_reg;
          OFS_MINUTES: read_data_next = minutes_reg;
          OFS_SECONDS: read_data_next = seconds_reg;
          default:     read_data_next = '0;
        endcase
      end
      MODE_WRITE: begin
        case (offset)
          OFS_HOURS:   hours_reg_next = write_data;
          OFS_MINUTES: minutes_reg_next = write_data;
          OFS_SECONDS: begin
            seconds_reg_next        = write_data;
            cycle_prescaler_next    = PRESC_RELOAD;
            hundredths_counter_next = HUND_RELOAD;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_prescaler    <= PRESC_RELOAD;
      hundredths_counter <= HUND_RELOAD;
      seconds_reg        <= '0;
      minutes_reg        <= '0;
      hours_reg          <= '0;
      out_valid          <= 1'b0;
      read_data          <= '0;
    end else begin
      if (accept) begin
        cycle_prescaler    <= cycle_prescaler_next;
        hundredths_counter <= hundredths_counter_next;
        seconds_reg        <= seconds_reg_next;
        minutes_reg        <= minutes_reg_next;
        hours_reg          <= hours_reg_next;
        read_data          <= read_data_next;
        out_valid          <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_non_read_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode != MODE_READ)) |=> (read_data == '0))
    else $error("non-read transaction returned nonzero data");

  a_hund_nonzero: assert property (@(posedge clk) disable iff (rst)
    (hundredths_counter != '0) && (cycle_prescaler != '0)
    && (cycle_prescaler <= PRESC_RELOAD))
    else $error("prescaler or hundredths counter out of range");

  a_sec_write_reload: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_WRITE) && (offset == OFS_SECONDS))
    |=> ((cycle_prescaler == PRESC_RELOAD) && (hundredths_counter == HUND_RELOAD)))
    else $error("seconds write did not reload prescalers");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("transaction accepted over a stalled result");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bmtod_pkg::*;

  localparam logic [MODE_W-1:0]   MODE_UNUSED   = 2'd3;
  localparam logic [OFFSET_W-1:0] OFS_UNMAPPED  = 2'd3;
  localparam int                  RESET_CYCLES  = 11;
  localparam int                  MAX_IDLE      = 12;
  localparam int                  SETTLE_CYCLES = 4;
  localparam int                  CYCLE_LIMIT   = 600000;
  localparam int                  ROLLOVER_RUNS = 8;
  localparam int                  RANDOM_ITEMS  = 250;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [MODE_W-1:0]     mode;
  logic [OFFSET_W-1:0]   offset;
  logic [DATA_W-1:0]     write_data;
  logic [CYCLES_W-1:0]   elapsed_cycles;
  logic                  out_valid;
  logic                  out_ready;
  logic [DATA_W-1:0]     read_data;

  // Separate idle profiles for the sender and the receiver
  int tx_gap_max  = MAX_IDLE;
  int rx_stall_max = MAX_IDLE;

  int n_errors    = 0;
  int cycle_count = 0;

  logic [DATA_W-1:0] expected_read_data[$];

  // Shadow time-of-day state
  logic [PRESCALER_W-1:0] tod_prescaler  = PRESCALER_W'(DEFAULT_CYCLES_PER_HUNDREDTH);
  logic [HUNDREDTH_W-1:0] tod_hundredths = HUNDREDTH_W'(DEFAULT_HUNDREDTHS_PER_SECOND);
  logic [DATA_W-1:0]      tod_hours      = '0;
  logic [DATA_W-1:0]      tod_minutes    = '0;
  logic [DATA_W-1:0]      tod_seconds    = '0;

  bus_mapped_time_of_day_clock dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .offset         (offset),
    .write_data     (write_data),
    .elapsed_cycles (elapsed_cycles),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run-time watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Seconds carry chain; bytes wrap at 256 before the compare
  function automatic void advance_second();
    tod_seconds = tod_seconds + 8'd1;
    if (tod_seconds >= SECONDS_LIMIT) begin
      tod_seconds = '0;
      tod_minutes = tod_minutes + 8'd1;
      if (tod_minutes >= MINUTES_LIMIT) begin
        tod_minutes = '0;
        tod_hours   = tod_hours + 8'd1;
        if (tod_hours >= HOURS_LIMIT) tod_hours = '0;
      end
    end
  endfunction

  function automatic void apply_tick(input logic [CYCLES_W-1:0] cycles);
    int remaining;
    if (cycles == '0) return;
    remaining = int'(tod_prescaler) - int'(cycles);
    if (remaining <= 0) begin
      remaining += DEFAULT_CYCLES_PER_HUNDREDTH;
      if (tod_hundredths > 0) tod_hundredths = tod_hundredths - 1'b1;
      if (tod_hundredths == 0) begin
        tod_hundredths = HUNDREDTH_W'(DEFAULT_HUNDREDTHS_PER_SECOND);
        advance_second();
      end
    end
    if (remaining < 0) remaining = 0;
    tod_prescaler = remaining[PRESCALER_W-1:0];
  endfunction

  // Updates the shadow state for one transaction and returns its read_data
  function automatic logic [DATA_W-1:0] predict_bus_access(
    input logic [MODE_W-1:0]   m,
    input logic [OFFSET_W-1:0] o,
    input logic [DATA_W-1:0]   d,
    input logic [CYCLES_W-1:0] c
  );
    logic [DATA_W-1:0] rd;
    rd = '0;
    case (m)
      MODE_TICK: apply_tick(c);
      MODE_READ: begin
        case (o)
          OFS_HOURS:   rd = tod_hours;
          OFS_MINUTES: rd = tod_minutes;
          OFS_SECONDS: rd = tod_seconds;
          default:     rd = '0;
        endcase
      end
      MODE_WRITE: begin
        case (o)
          OFS_HOURS:   tod_hours = d;
          OFS_MINUTES: tod_minutes = d;
          OFS_SECONDS: begin
            tod_seconds    = d;
            tod_prescaler  = PRESCALER_W'(DEFAULT_CYCLES_PER_HUNDREDTH);
            tod_hundredths = HUNDREDTH_W'(DEFAULT_HUNDREDTHS_PER_SECOND);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return rd;
  endfunction

  // Drive one transaction and record its expected result on acceptance
  task automatic send_item(
    input logic [MODE_W-1:0]   m,
    input logic [OFFSET_W-1:0] o,
    input logic [DATA_W-1:0]   d,
    input logic [CYCLES_W-1:0] c
  );
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    offset         <= o;
    write_data     <= d;
    elapsed_cycles <= c;
    do @(posedge clk); while (!in_ready);
    expected_read_data.push_back(predict_bus_access(m, o, d, c));
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_read_data.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle_profile();
    case ($urandom_range(0, 4))
      0: begin tx_gap_max = 0;        rx_stall_max = 0;        end
      1: begin tx_gap_max = MAX_IDLE; rx_stall_max = 0;        end
      2: begin tx_gap_max = 0;        rx_stall_max = MAX_IDLE; end
      3: begin tx_gap_max = 3;        rx_stall_max = 3;        end
      default: begin tx_gap_max = MAX_IDLE; rx_stall_max = MAX_IDLE; end
    endcase
  endtask

  // Favor values at and past the carry limit
  function automatic logic [DATA_W-1:0] pick_time_byte(input int limit);
    case ($urandom_range(0, 3))
      0: return DATA_W'(limit - 1);
      1: return DATA_W'($urandom_range(limit, 255));
      2: return DATA_W'($urandom_range(0, limit - 1));
      default: return '1;
    endcase
  endfunction

  // Mostly large tick counts so seconds advance in a reasonable number of items
  function automatic logic [CYCLES_W-1:0] draw_tick_cycles();
    if ($urandom_range(0, 3) == 0) return CYCLES_W'($urandom_range(0, 8191));
    return CYCLES_W'($urandom_range(4096, 8191));
  endfunction

  // Receive results with random back-pressure and compare against predictions
  initial begin : result_checker
    int stall;
    logic [DATA_W-1:0] want;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_read_data.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual read_data %0d",
                 $time, read_data);
        n_errors++;
      end else begin
        want = expected_read_data.pop_front();
        if (read_data !== want) begin
          $display("%0t: read_data mismatch, expected %0d, actual %0d",
                   $time, want, read_data);
          n_errors++;
        end
      end
    end
  end

  // Registers read back as zero after reset; unused mode is ignored
  task automatic test_reset_state();
    send_item(MODE_READ, OFS_HOURS, '0, '0);
    send_item(MODE_READ, OFS_MINUTES, '1, '1);
    send_item(MODE_READ, OFS_SECONDS, '0, '0);
    send_item(MODE_READ, OFS_UNMAPPED, '1, '1);
    send_item(MODE_UNUSED, OFS_SECONDS, '1, '1);
  endtask

  // Byte extremes on every offset, unmapped writes dropped
  task automatic test_register_extremes();
    logic [OFFSET_W-1:0] o;
    for (int i = 0; i < 4; i++) begin
      o = OFFSET_W'(i);
      send_item(MODE_WRITE, o, 8'hFF, '0);
      send_item(MODE_READ, o, '0, '0);
      send_item(MODE_WRITE, o, 8'h00, '1);
      send_item(MODE_READ, o, '1, '1);
    end
  endtask

  // Zero, smallest and largest tick, then a seconds write to reload the prescalers
  task automatic test_tick_extremes();
    send_item(MODE_TICK, OFS_HOURS, '1, '0);
    send_item(MODE_TICK, OFS_UNMAPPED, '0, '1);
    send_item(MODE_TICK, OFS_SECONDS, '0, 13'd1);
    send_item(MODE_WRITE, OFS_SECONDS, 8'd59, '1);
  endtask

  // Load a time near a carry, tick until seconds move, then read it all back
  task automatic test_time_rollover(input int runs);
    logic [DATA_W-1:0] start_seconds;
    for (int r = 0; r < runs; r++) begin
      set_idle_profile();
      if ($urandom_range(0, 1))
        send_item(MODE_WRITE, OFS_HOURS, pick_time_byte(HOURS_LIMIT), draw_tick_cycles());
      if ($urandom_range(0, 1))
        send_item(MODE_WRITE, OFS_MINUTES, pick_time_byte(MINUTES_LIMIT), draw_tick_cycles());
      send_item(MODE_WRITE, OFS_SECONDS, pick_time_byte(SECONDS_LIMIT), draw_tick_cycles());
      start_seconds = tod_seconds;
      while (tod_seconds == start_seconds) begin
        if ($urandom_range(0, 15) == 0)
          send_item(MODE_READ, OFFSET_W'($urandom_range(0, 3)), DATA_W'($urandom),
                    draw_tick_cycles());
        else
          send_item(MODE_TICK, OFFSET_W'($urandom_range(0, 3)), DATA_W'($urandom),
                    draw_tick_cycles());
      end
      send_item(MODE_READ, OFS_SECONDS, DATA_W'($urandom), '0);
      send_item(MODE_READ, OFS_MINUTES, DATA_W'($urandom), '0);
      send_item(MODE_READ, OFS_HOURS, DATA_W'($urandom), '0);
    end
  endtask

  // Unstructured mix of every mode and offset
  task automatic test_random_traffic(input int count);
    int pick;
    logic [MODE_W-1:0] m;
    tx_gap_max   = MAX_IDLE;
    rx_stall_max = MAX_IDLE;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 15);
      if (pick < 8)       m = MODE_TICK;
      else if (pick < 12) m = MODE_READ;
      else if (pick < 15) m = MODE_WRITE;
      else                m = MODE_UNUSED;
      send_item(m, OFFSET_W'($urandom_range(0, 3)), DATA_W'($urandom),
                CYCLES_W'($urandom_range(0, 8191)));
    end
  endtask

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    mode           <= MODE_TICK;
    offset         <= OFS_HOURS;
    write_data     <= '0;
    elapsed_cycles <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_extremes();
    test_tick_extremes();
    wait_drained();
    test_time_rollover(ROLLOVER_RUNS);
    wait_drained();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
